// File: rtl/cpwm_pkg.sv
// Package for the complementary PWM with dead-time insertion.
// Holds the shared widths, codes, reset values and the item, result and config types.
// No dependencies.
package cpwm_pkg;

  localparam int unsigned DUTY_BITS    = 16;
  localparam int unsigned PERIOD_BITS  = 16;
  localparam int unsigned DEAD_BITS    = 8;
  localparam int unsigned CMP_BITS     = 16;
  localparam int unsigned REG_IDX_BITS = 3;
  localparam int unsigned REG_DATA_BITS = 16;

  // operation codes
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_DUTY = 1'b1;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_PERIOD         = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DEAD_TIME_HIGH = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DEAD_TIME_LOW  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_COMPARE    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_COMPARE    = 3'd4;

  // register reset values
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET      = 16'd159;
  localparam logic [DEAD_BITS-1:0]   DEAD_TIME_RESET   = 8'd6;
  localparam logic [CMP_BITS-1:0]    MIN_COMPARE_RESET = 16'd8;
  localparam logic [CMP_BITS-1:0]    MAX_COMPARE_RESET = 16'd151;

  localparam logic [DEAD_BITS-1:0] SINCE_EDGE_MAX = 8'hFF;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic [DEAD_BITS-1:0]   dead_time_high;
    logic [DEAD_BITS-1:0]   dead_time_low;
    logic [CMP_BITS-1:0]    min_compare;
    logic [CMP_BITS-1:0]    max_compare;
  } cfg_t;

  typedef struct packed {
    logic                 operation;
    logic [DUTY_BITS-1:0] duty;
  } item_t;

  typedef struct packed {
    logic                high_side;
    logic                low_side;
    logic                outputs_connected;
    logic [CMP_BITS-1:0] live_compare;
    logic                period_start;
  } result_t;

endpackage

// File: rtl/cpwm_if.sv
// Valid/ready channel interfaces for the complementary PWM block.
// Depends on cpwm_pkg for field widths.
interface cpwm_item_if import cpwm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [DUTY_BITS-1:0] duty;

  modport source (output valid, operation, duty, input ready);
  modport sink   (input valid, operation, duty, output ready);
endinterface

interface cpwm_result_if import cpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                high_side;
  logic                low_side;
  logic                outputs_connected;
  logic [CMP_BITS-1:0] live_compare;
  logic                period_start;

  modport source (output valid, high_side, low_side, outputs_connected, live_compare,
                  period_start, input ready);
  modport sink   (input valid, high_side, low_side, outputs_connected, live_compare,
                  period_start, output ready);
endinterface

interface cpwm_cfg_if import cpwm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REG_IDX_BITS-1:0]  index;
  logic [REG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/cpwm_cfg_regs.sv
// Configuration register file of the complementary PWM block.
// Depends on cpwm_pkg and the cpwm_cfg_if channel.
module cpwm_cfg_regs import cpwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cpwm_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.period         <= PERIOD_RESET;
      regs.dead_time_high <= DEAD_TIME_RESET;
      regs.dead_time_low  <= DEAD_TIME_RESET;
      regs.min_compare    <= MIN_COMPARE_RESET;
      regs.max_compare    <= MAX_COMPARE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PERIOD:         regs.period         <= cfg.data[PERIOD_BITS-1:0];
        REG_DEAD_TIME_HIGH: regs.dead_time_high <= cfg.data[DEAD_BITS-1:0];
        REG_DEAD_TIME_LOW:  regs.dead_time_low  <= cfg.data[DEAD_BITS-1:0];
        REG_MIN_COMPARE:    regs.min_compare    <= cfg.data[CMP_BITS-1:0];
        REG_MAX_COMPARE:    regs.max_compare    <= cfg.data[CMP_BITS-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// File: rtl/cpwm_duty_scale.sv
// Duty scaling: duty * period / 65535, clamped to min_compare then max_compare.
// Depends on cpwm_pkg.
module cpwm_duty_scale import cpwm_pkg::*; (
  input  logic [DUTY_BITS-1:0] duty,
  input  cfg_t                 regs,
  output logic [CMP_BITS-1:0]  compare
);

  logic [31:0]         product;
  logic [31:0]         rounded;
  logic [CMP_BITS-1:0] quotient;
  logic [CMP_BITS-1:0] floored;

  // x / 65535 == (x + (x >> 16) + 1) >> 16 for any x up to 65535 * 65535,
  // and the sum stays within 32 bits over that range
  assign product  = 32'(duty) * 32'(regs.period);
  assign rounded  = product + 32'(product[31:16]) + 32'd1;
  assign quotient = rounded[31:16];

  assign floored = (quotient < regs.min_compare) ? regs.min_compare : quotient;
  assign compare = (floored > regs.max_compare) ? regs.max_compare : floored;

endmodule

// File: rtl/cpwm_core.sv
// PWM state: counter, live and buffered compare, connect flag and dead-time tracking.
// Updates on each fired item and gives that item's result.
// Depends on cpwm_pkg and cpwm_duty_scale.
module cpwm_core import cpwm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item_q,
  input  cfg_t    regs,
  output result_t res
);

  localparam int unsigned WIDE_BITS = (COUNT_BITS > CMP_BITS) ? COUNT_BITS : CMP_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] count;
  logic [CMP_BITS-1:0]   compare_now;
  logic [CMP_BITS-1:0]   compare_buffer;
  logic                  buffer_pending;
  logic                  connected;
  logic                  raw_previous;
  logic [DEAD_BITS-1:0]  since_edge;

  logic [COUNT_BITS-1:0] count_next;
  logic [CMP_BITS-1:0]   compare_now_next;
  logic [CMP_BITS-1:0]   compare_buffer_next;
  logic                  buffer_pending_next;
  logic                  connected_next;
  logic                  raw_previous_next;
  logic [DEAD_BITS-1:0]  since_edge_next;
  logic                  wrap;

  logic [CMP_BITS-1:0]   scaled;
  logic [WIDE_BITS-1:0]  period_wide;
  logic [WIDE_BITS-1:0]  top_wide;
  logic                  raw;

  cpwm_duty_scale u_scale (
    .duty    (item_q.duty),
    .regs    (regs),
    .compare (scaled)
  );

  // top count saturates at what the counter can hold
  assign period_wide = WIDE_BITS'(regs.period);
  assign top_wide    = (period_wide > WIDE_BITS'(COUNT_MAX)) ? WIDE_BITS'(COUNT_MAX)
                                                              : period_wide;

  always_comb begin
    count_next          = count;
    compare_now_next    = compare_now;
    compare_buffer_next = compare_buffer;
    buffer_pending_next = buffer_pending;
    connected_next      = connected;
    raw_previous_next   = raw_previous;
    since_edge_next     = since_edge;
    wrap                = 1'b0;
    raw                 = 1'b0;

    if (item_q.operation == OP_TICK) begin
      if (WIDE_BITS'(count) >= top_wide) begin
        count_next = '0;
        wrap       = 1'b1;
        if (buffer_pending) begin
          compare_now_next    = compare_buffer;
          buffer_pending_next = 1'b0;
        end
      end else begin
        count_next = count + COUNT_BITS'(1);
      end
      raw = WIDE_BITS'(count_next) < WIDE_BITS'(compare_now_next);
      if (raw != raw_previous) begin
        since_edge_next = '0;
      end else if (since_edge != SINCE_EDGE_MAX) begin
        since_edge_next = since_edge + DEAD_BITS'(1);
      end
      raw_previous_next = raw;
    end else if (item_q.duty == '0) begin
      connected_next      = 1'b0;
      compare_buffer_next = '0;
      compare_now_next    = '0;
      buffer_pending_next = 1'b0;
    end else begin
      compare_buffer_next = scaled;
      if (!connected) begin
        compare_now_next    = scaled;
        buffer_pending_next = 1'b0;
        connected_next      = 1'b1;
      end else begin
        buffer_pending_next = 1'b1;
      end
    end

    res.high_side         = connected_next && raw_previous_next &&
                            (since_edge_next >= regs.dead_time_high);
    res.low_side          = connected_next && !raw_previous_next &&
                            (since_edge_next >= regs.dead_time_low);
    res.outputs_connected = connected_next;
    res.live_compare      = compare_now_next;
    res.period_start      = wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      compare_now    <= '0;
      compare_buffer <= '0;
      buffer_pending <= 1'b0;
      connected      <= 1'b0;
      raw_previous   <= 1'b0;
      since_edge     <= '0;
    end else if (fire) begin
      count          <= count_next;
      compare_now    <= compare_now_next;
      compare_buffer <= compare_buffer_next;
      buffer_pending <= buffer_pending_next;
      connected      <= connected_next;
      raw_previous   <= raw_previous_next;
      since_edge     <= since_edge_next;
    end
  end

  // both gates never on together
  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    !(res.high_side && res.low_side))
    else $error("high and low side driven together");

  // zero duty clears compare, buffer and connection
  a_zero_duty_off: assert property (@(posedge clk) disable iff (rst)
    fire && item_q.operation == OP_SET_DUTY && item_q.duty == '0 |=>
      !connected && compare_now == '0 && !buffer_pending)
    else $error("zero duty did not disconnect");

  // a wrap always consumes a pending buffer
  a_wrap_loads: assert property (@(posedge clk) disable iff (rst)
    fire && item_q.operation == OP_TICK && wrap && buffer_pending |=>
      !buffer_pending && compare_now == $past(compare_buffer))
    else $error("pending compare not loaded at wrap");

  // a buffer can be pending only while connected
  a_pending_connected: assert property (@(posedge clk) disable iff (rst)
    buffer_pending |-> connected)
    else $error("compare pending while disconnected");

endmodule

// File: rtl/complementary_pwm_dead_time.sv
// Complementary PWM with dead-time insertion for a synchronous buck gate drive.
//
// Channels: 'item' takes transactions of {operation, duty}. A tick advances the
// single-slope counter (0..period inclusive) by one count; a set-duty
// transaction scales duty*period/65535, clamps it to min_compare..max_compare
// and buffers it until the next wrap (loads it at once when the outputs were
// off; zero duty turns them off). 'result' returns one transaction per item:
// gate levels, connect flag, live compare and a period-start flag. 'cfg' writes
// the five registers by index; it is always ready, use it only while idle.
//
// An accepted item sits in the input register until the result register is
// free, is then processed and lands in the result register to be offered.
// Throughput: one transaction per cycle while results are taken, set by the
// combinational update of counter and compare (16x16 multiply, reciprocal
// divide and clamp in one path).
//
// Reset (rst, synchronous): counter, compares and dead-time tracking cleared,
// outputs disconnected, no result valid, registers to defaults. When the result
// receiver stalls, the held result stays stable, the input register still
// takes one more transaction, and then 'item' ready drops until space frees.
module complementary_pwm_dead_time import cpwm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  cpwm_item_if.sink    item,
  cpwm_result_if.source result,
  cpwm_cfg_if.sink     cfg
);

  cfg_t    regs;
  item_t   item_q;
  logic    item_valid;
  result_t res_next;
  result_t result_q;
  logic    result_valid;
  logic    out_free;
  logic    fire;

  cpwm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // result register is free when empty or being taken this cycle
  assign out_free   = !result_valid || result.ready;
  assign fire       = item_valid && out_free;
  assign item.ready = !item_valid || out_free;

  // input register: hold the transaction until it is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      item_q.operation <= item.operation;
      item_q.duty      <= item.duty;
    end
  end

  cpwm_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item_q (item_q),
    .regs   (regs),
    .res    (res_next)
  );

  // result register: advance on fire, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= res_next;
    end
  end

  assign result.valid             = result_valid;
  assign result.high_side         = result_q.high_side;
  assign result.low_side          = result_q.low_side;
  assign result.outputs_connected = result_q.outputs_connected;
  assign result.live_compare      = result_q.live_compare;
  assign result.period_start      = result_q.period_start;

endmodule

// File: tb/cpwm_drive_check.sv
`timescale 1ns / 1ps
// Checker for the complementary PWM gate drive: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on cpwm_pkg and the channel interfaces of cpwm_if.sv.
module cpwm_drive_check import cpwm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  cpwm_item_if        item,
  cpwm_result_if      result,
  cpwm_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned in_flight
);

  localparam logic [31:0] COUNT_TOP   = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [31:0] FULL_SCALE  = 32'd65535;
  localparam int unsigned MAX_REPORTS = 10;

  cfg_t                 regs;
  logic [31:0]          count;
  logic [CMP_BITS-1:0]  cmp_live;
  logic [CMP_BITS-1:0]  cmp_next;
  logic                 next_loaded;
  logic                 connected;
  logic                 raw_level;
  logic [DEAD_BITS-1:0] since_edge;
  result_t              drive_q[$];

  always @(posedge clk) begin : watch
    result_t     want;
    result_t     got;
    logic [31:0] top;
    logic [31:0] scaled;
    logic        wrapped;
    logic        raw;
    if (rst) begin
      regs        = '{PERIOD_RESET, DEAD_TIME_RESET, DEAD_TIME_RESET,
                      MIN_COMPARE_RESET, MAX_COMPARE_RESET};
      count       = '0;
      cmp_live    = '0;
      cmp_next    = '0;
      next_loaded = 1'b0;
      connected   = 1'b0;
      raw_level   = 1'b0;
      since_edge  = '0;
      drive_q.delete();
    end else begin
      // a result never leaves in the same cycle as its item, so check first
      if (result.valid && result.ready) begin
        got = '{result.high_side, result.low_side, result.outputs_connected,
                result.live_compare, result.period_start};
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing outstanding: hs=%0b ls=%0b conn=%0b cmp=%0d ps=%0b",
                     $time, got.high_side, got.low_side, got.outputs_connected,
                     got.live_compare, got.period_start);
        end else begin
          want = drive_q.pop_front();
          if (got.high_side !== want.high_side || got.low_side !== want.low_side ||
              got.outputs_connected !== want.outputs_connected ||
              got.live_compare !== want.live_compare ||
              got.period_start !== want.period_start) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: drive mismatch: expected hs=%0b ls=%0b conn=%0b cmp=%0d ps=%0b, got hs=%0b ls=%0b conn=%0b cmp=%0d ps=%0b",
                       $time, want.high_side, want.low_side, want.outputs_connected,
                       want.live_compare, want.period_start, got.high_side, got.low_side,
                       got.outputs_connected, got.live_compare, got.period_start);
          end
        end
      end

      if (item.valid && item.ready) begin
        wrapped = 1'b0;
        if (item.operation == OP_TICK) begin
          top = (32'(regs.period) > COUNT_TOP) ? COUNT_TOP : 32'(regs.period);
          if (count >= top) begin
            count   = '0;
            wrapped = 1'b1;
            if (next_loaded) begin
              cmp_live    = cmp_next;
              next_loaded = 1'b0;
            end
          end else begin
            count = (count + 32'd1) & COUNT_TOP;
          end
          raw = count < 32'(cmp_live);
          if (raw != raw_level)
            since_edge = '0;
          else if (since_edge != SINCE_EDGE_MAX)
            since_edge = since_edge + 1'b1;
          raw_level = raw;
        end else if (item.duty == '0) begin
          connected   = 1'b0;
          cmp_live    = '0;
          cmp_next    = '0;
          next_loaded = 1'b0;
        end else begin
          // minimum clamp first, so min above max settles on max
          scaled = (32'(item.duty) * 32'(regs.period)) / FULL_SCALE;
          if (scaled < 32'(regs.min_compare)) scaled = 32'(regs.min_compare);
          if (scaled > 32'(regs.max_compare)) scaled = 32'(regs.max_compare);
          cmp_next = scaled[CMP_BITS-1:0];
          if (!connected) begin
            cmp_live    = cmp_next;
            next_loaded = 1'b0;
            connected   = 1'b1;
          end else begin
            next_loaded = 1'b1;
          end
        end
        want.high_side         = connected && raw_level &&
                                 (since_edge >= regs.dead_time_high);
        want.low_side          = connected && !raw_level &&
                                 (since_edge >= regs.dead_time_low);
        want.outputs_connected = connected;
        want.live_compare      = cmp_live;
        want.period_start      = wrapped;
        drive_q.push_back(want);
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PERIOD:         regs.period         = cfg.data[PERIOD_BITS-1:0];
          REG_DEAD_TIME_HIGH: regs.dead_time_high = cfg.data[DEAD_BITS-1:0];
          REG_DEAD_TIME_LOW:  regs.dead_time_low  = cfg.data[DEAD_BITS-1:0];
          REG_MIN_COMPARE:    regs.min_compare    = cfg.data[CMP_BITS-1:0];
          REG_MAX_COMPARE:    regs.max_compare    = cfg.data[CMP_BITS-1:0];
          default: ;
        endcase
      end
    end
    in_flight = drive_q.size();
  end

endmodule

// File: tb/tb_complementary_pwm_dead_time.sv
`timescale 1ns / 1ps
// Top of the complementary PWM testbench: clock, reset, register settings and
// item and result traffic with random idling; verdict from cpwm_drive_check.
// Depends on cpwm_pkg, cpwm_if.sv, the block and cpwm_drive_check.
module tb_complementary_pwm_dead_time;
  import cpwm_pkg::*;

  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned HOLD_PHASE = 1;
  localparam int unsigned HOLD_LEN   = 48;
  localparam int unsigned DRAIN_WAIT = 8;
  // index with no register behind it; writes to it must change nothing
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    cfg_t        regs;
    int unsigned items;
    int unsigned tick_pct;
    bit          zero_ok;
  } phase_t;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned in_flight;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b0;
  int unsigned rx_hold = 0;
  phase_t      plan [NUM_PHASES];

  cpwm_item_if   item_ch ();
  cpwm_result_if result_ch ();
  cpwm_cfg_if    cfg_ch ();

  complementary_pwm_dead_time #(.COUNT_BITS(16)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cpwm_drive_check #(.COUNT_BITS(16)) drive_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Offer one item transaction (random gap if tx_idle) and hold it until taken.
  // Lower valid only in gap cycles, so a back-to-back item keeps it high.
  task automatic send_item(input logic op, input logic [DUTY_BITS-1:0] duty);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.duty      <= duty;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Write one register and drop valid again on the next falling edge.
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [REG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering items, wait for every outstanding result, then rewrite all
  // registers. Dead-time writes carry random upper bits, which the block drops.
  task automatic load_setting(input cfg_t s);
    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (in_flight == 0);
    write_reg(REG_PERIOD, s.period);
    write_reg(REG_DEAD_TIME_HIGH, {8'($urandom), s.dead_time_high});
    write_reg(REG_DEAD_TIME_LOW, {8'($urandom), s.dead_time_low});
    write_reg(REG_MIN_COMPARE, s.min_compare);
    write_reg(REG_MAX_COMPARE, s.max_compare);
    write_reg(REG_UNUSED, 16'($urandom));
  endtask

  // Result side: draw a stall per transaction if rx_idle, or take a long hold-off
  // when one is requested, then keep ready high until a result is accepted.
  initial begin : result_drain
    int unsigned stall;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 7) : 0;
      end
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin : stimulus
    int unsigned            pick;
    logic [DUTY_BITS-1:0]   level;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_TICK;
    item_ch.duty      = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_PERIOD;
    cfg_ch.data       = '0;
    rst               = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings, one per phase, extremes among them:
    // defaults (leaves the count high for the next phase);
    // short period below the old count, zero dead times, full clamp window;
    // compare above the top count with a 255-tick high dead time, so the
    //   edge counter saturates;
    // minimum above maximum; the largest period with everything clamped high;
    // the shortest nonzero period; and one drawn at random.
    plan[0] = '{'{16'd159, 8'd6, 8'd6, 16'd8, 16'd151}, 25, 75, 1'b1};
    plan[1] = '{'{16'd10, 8'd0, 8'd0, 16'd0, 16'hFFFF}, 25, 70, 1'b1};
    plan[2] = '{'{16'd5, 8'd255, 8'd3, 16'd6, 16'd6}, 290, 98, 1'b0};
    plan[3] = '{'{16'd200, 8'd20, 8'd40, 16'd250, 16'd30}, 20, 80, 1'b1};
    plan[4] = '{'{16'hFFFF, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF}, 15, 60, 1'b1};
    plan[5] = '{'{16'd1, 8'd0, 8'd1, 16'd0, 16'd2}, 20, 75, 1'b1};
    plan[6] = '{'{16'($urandom_range(1, 48)), 8'($urandom_range(0, 7)),
                  8'($urandom_range(0, 7)), 16'($urandom_range(0, 20)),
                  16'($urandom_range(0, 60))}, 25, 75, 1'b1};

    // Directed run on a tiny period so wraps come quickly.
    load_setting('{16'd4, 8'd1, 8'd2, 16'd1, 16'd3});
    send_item(OP_TICK, 16'($urandom));          // tick while disconnected
    send_item(OP_SET_DUTY, 16'h0000);           // zero duty while already off
    send_item(OP_SET_DUTY, 16'hFFFF);           // first duty loads at once, clamps to max
    repeat (6) send_item(OP_TICK, 16'($urandom));
    send_item(OP_SET_DUTY, 16'h0001);           // scales to zero, clamps to min, buffered
    send_item(OP_SET_DUTY, 16'h8000);           // overwrite the buffer before the wrap
    repeat (6) send_item(OP_TICK, 16'($urandom));
    send_item(OP_SET_DUTY, 16'h4000);
    send_item(OP_SET_DUTY, 16'h0000);           // disconnect with a value still buffered
    repeat (3) send_item(OP_TICK, 16'($urandom));
    send_item(OP_SET_DUTY, 16'h7FFF);           // reconnect
    send_item(OP_TICK, 16'($urandom));

    // Random phases: mostly ticks with duty changes sprinkled in. Cycle the
    // idling through both sides, neither, sender only and receiver only.
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle = (p % 4 == 0) || (p % 4 == 2);
      rx_idle = (p % 4 == 0) || (p % 4 == 3);
      load_setting(plan[p].regs);
      // hold the result side off while items keep coming, to back the block up
      if (p == HOLD_PHASE) rx_hold = HOLD_LEN;
      send_item(OP_SET_DUTY, 16'($urandom_range(1, 65535)));
      repeat (plan[p].items) begin
        pick = $urandom_range(0, 99);
        if (pick < plan[p].tick_pct) begin
          send_item(OP_TICK, 16'($urandom));
        end else begin
          case ($urandom_range(0, 5))
            0:       level = '0;
            1:       level = 16'hFFFF;
            2:       level = 16'h0001;
            default: level = 16'($urandom);
          endcase
          if (!plan[p].zero_ok && level == '0) level = 16'h0001;
          send_item(OP_SET_DUTY, level);
        end
      end
    end

    // Drain: stop offering, wait for every result, allow for the pipeline.
    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (in_flight == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("tb_complementary_pwm_dead_time: PASS");
    else
      $display("tb_complementary_pwm_dead_time: FAIL");
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $display("tb_complementary_pwm_dead_time: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cpwm_pkg.sv
rtl/cpwm_if.sv
rtl/cpwm_cfg_regs.sv
rtl/cpwm_duty_scale.sv
rtl/cpwm_core.sv
rtl/complementary_pwm_dead_time.sv
tb/cpwm_drive_check.sv
tb/tb_complementary_pwm_dead_time.sv
